[rtl/spooky_style_hash_128_macros.svh]
// Assertion macros shared by the checker of the hash block
`ifndef SPOOKY_STYLE_HASH_128_MACROS_SVH
`define SPOOKY_STYLE_HASH_128_MACROS_SVH

// Implication checked from the next cycle on, masked during reset
`define SPK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spk check failed");

// Implication from reset itself, not masked by reset
`define SPK_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("spk reset check failed");

`endif

[rtl/spk_pkg.sv]
// Package: constants, types and mixing functions of the hash block
`timescale 1ns / 1ps
package spk_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int OFF_W       = LENGTH_BITS + 1;
   localparam int LANES       = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam logic [63:0] SPK_CONST = 64'hdeadbeefdeadbeef;
   localparam int SHORT_LIMIT = 192;
   localparam int BLOCK_BYTES = 96;
   // reciprocal of the block size for the remainder at the end of a long message
   localparam int RECIP_SHIFT = LENGTH_BITS + 6;
   localparam logic [LENGTH_BITS-1:0] RECIP =
      LENGTH_BITS'(((64'd1 << RECIP_SHIFT) / BLOCK_BYTES) + 64'd1);

   typedef logic [LANES-1:0][63:0] lanes_type;

   typedef enum logic [2:0] {
      OP_SH_ADD2, OP_SH_ADD3_MIX, OP_SH_XOR2, OP_SH_XOR3_MIX,
      OP_SH_ADD3, OP_LG_ADD, OP_LG_ADD_ROUND, OP_LG_ADD2
   } op_type;

   typedef struct packed {
      logic                   init;
      logic                   is_long;
      logic [LENGTH_BITS-1:0] len;
      logic [63:0]            seed1;
      logic [63:0]            seed2;
      logic                   absorb;
      op_type                 op;
      logic [3:0]             lane;
      logic [63:0]            word;
      logic                   last;
   } entry_type;

   typedef enum logic [3:0] {
      ST_RUN, ST_SMIX, ST_ROUND, ST_FIN_MUL, ST_FIN_ADD,
      ST_FIN_SH1, ST_FIN_SH2, ST_FIN_SH3, ST_FIN_OUT
   } state_type;

   function automatic logic [5:0] lane_rot(input logic [3:0] j);
      logic [5:0] r;
      case (j)
         4'd0:    r = 6'd44;
         4'd1:    r = 6'd15;
         4'd2:    r = 6'd34;
         4'd3:    r = 6'd21;
         4'd4:    r = 6'd14;
         4'd5:    r = 6'd13;
         4'd6:    r = 6'd11;
         4'd7:    r = 6'd25;
         4'd8:    r = 6'd42;
         4'd9:    r = 6'd9;
         4'd10:   r = 6'd35;
         4'd11:   r = 6'd39;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
      logic [127:0] d;
      d = {x, x} << r;
      return d[127:64];
   endfunction

   // one step of the twelve-lane round
   function automatic lanes_type round_step(input lanes_type h, input logic [3:0] j,
                                            input logic add_first);
      logic [3:0] p, q, s;
      lanes_type  o;
      p = (j == 4'd0) ? 4'd11 : j - 4'd1;
      q = (j == 4'd11) ? 4'd0 : j + 4'd1;
      s = (j >= 4'd10) ? j - 4'd10 : j + 4'd2;
      o = h;
      o[p] = add_first ? o[p] + o[q] : o[p] ^ o[q];
      o[s] = o[s] ^ o[p];
      o[q] = rotl(o[q], lane_rot(j));
      return o;
   endfunction

   function automatic lanes_type short_mix(input lanes_type h, input logic alt);
      lanes_type o;
      o = h;
      o[0] = rotl(o[0] ^ o[2], alt ? 6'd23 : 6'd50);
      o[3] = o[3] ^ o[0];
      o[1] = rotl(o[1] ^ o[3], alt ? 6'd5 : 6'd52);
      o[2] = o[2] ^ o[1];
      return o;
   endfunction

endpackage

[rtl/spk_queue.sv]
// Short request queue between the front and the back of the hash block
`timescale 1ns / 1ps
module spk_queue import spk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wdata,
   output logic      full,
   input  logic      pop,
   output entry_type rdata,
   output logic      empty
);
   entry_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= wdata;
      end
   end
endmodule

[rtl/spk_front.sv]
// Front end: takes message words, tracks position and classifies each request
`timescale 1ns / 1ps
module spk_front import spk_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [63:0]            req_data_word,
   input  logic [3:0]             req_valid_bytes,
   input  logic                   req_last,
   input  logic [31:0]            req_msg_length,
   input  logic [63:0]            req_seed_first,
   input  logic [63:0]            req_seed_second,
   input  logic                   q_full,
   output logic                   q_push,
   output entry_type              q_entry
);
   logic                   in_message_ff, in_message_in;
   logic [LENGTH_BITS-1:0] length_held_ff, length_held_in;
   logic                   long_path_ff, long_path_in;
   logic [OFF_W-1:0]       bytes_taken_ff, bytes_taken_in;
   logic [OFF_W-1:0]       blk_ff, blk_in;
   logic [3:0]             idx_ff, idx_in;

   logic                   first, is_long, active, full_block;
   logic [LENGTH_BITS-1:0] len, g_lim, t_lim;
   logic [OFF_W-1:0]       off, blk, rem;
   logic [OFF_W:0]         blk_end;
   logic [3:0]             idx, vs, n;
   logic [63:0]            mask;
   op_type                 op;

   assign q_push = req_push && !q_full;

   // position and classification of the word
   always_comb begin
      first   = !in_message_ff;
      len     = first ? req_msg_length[LENGTH_BITS-1:0] : length_held_ff;
      is_long = first ? (len >= LENGTH_BITS'(SHORT_LIMIT)) : long_path_ff;
      off     = first ? '0 : bytes_taken_ff;
      blk     = first ? '0 : blk_ff;
      idx     = first ? 4'd0 : idx_ff;
      active  = off < {1'b0, len};
      rem     = {1'b0, len} - off;
      vs      = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
      n       = (rem < OFF_W'(vs)) ? rem[3:0] : vs;
      for (int b = 0; b < 8; b++) begin
         mask[b*8 +: 8] = (4'(b) < n) ? 8'hff : 8'h00;
      end
      blk_end    = {1'b0, blk} + (OFF_W+1)'(BLOCK_BYTES);
      full_block = blk_end <= (OFF_W+1)'(len);
      g_lim      = len & ~LENGTH_BITS'(31);
      t_lim      = len & ~LENGTH_BITS'(15);
      if (is_long) begin
         if (full_block) begin
            op = (idx == 4'd11) ? OP_LG_ADD_ROUND : OP_LG_ADD;
         end else begin
            op = OP_LG_ADD2;
         end
      end else if (off < {1'b0, g_lim}) begin
         case (off[4:3])
            2'd0:    op = OP_SH_ADD2;
            2'd1:    op = OP_SH_ADD3_MIX;
            2'd2:    op = OP_SH_XOR2;
            default: op = OP_SH_XOR3_MIX;
         endcase
      end else if (off < {1'b0, t_lim}) begin
         op = off[3] ? OP_SH_ADD3_MIX : OP_SH_ADD2;
      end else begin
         op = off[3] ? OP_SH_ADD3 : OP_SH_ADD2;
      end
   end

   // request for the back end
   always_comb begin
      q_entry.init    = first;
      q_entry.is_long = is_long;
      q_entry.len     = len;
      q_entry.seed1   = req_seed_first;
      q_entry.seed2   = req_seed_second;
      q_entry.absorb  = active;
      q_entry.op      = op;
      q_entry.lane    = idx;
      q_entry.word    = req_data_word & mask;
      q_entry.last    = req_last;
   end

   // message state after this word
   always_comb begin
      in_message_in  = in_message_ff;
      length_held_in = length_held_ff;
      long_path_in   = long_path_ff;
      bytes_taken_in = bytes_taken_ff;
      blk_in         = blk_ff;
      idx_in         = idx_ff;
      if (q_push) begin
         in_message_in  = !req_last;
         length_held_in = len;
         long_path_in   = is_long;
         bytes_taken_in = active ? off + OFF_W'(8) : off;
         idx_in         = idx;
         blk_in         = blk;
         if (active) begin
            idx_in = (idx == 4'd11) ? 4'd0 : idx + 4'd1;
            if (idx == 4'd11) begin
               blk_in = blk + OFF_W'(BLOCK_BYTES);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff  <= 1'b0;
         length_held_ff <= '0;
         long_path_ff   <= 1'b0;
         bytes_taken_ff <= '0;
         blk_ff         <= '0;
         idx_ff         <= '0;
      end else begin
         in_message_ff  <= in_message_in;
         length_held_ff <= length_held_in;
         long_path_ff   <= long_path_in;
         bytes_taken_ff <= bytes_taken_in;
         blk_ff         <= blk_in;
         idx_ff         <= idx_in;
      end
   end
endmodule

[rtl/spk_back.sv]
// Back end: lane state, absorb, mixing rounds, finish and result register
`timescale 1ns / 1ps
module spk_back import spk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  entry_type   q_entry,
   input  logic        q_empty,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [63:0] rsp_hash_first,
   output logic [63:0] rsp_hash_second
);
   state_type                state_ff, state_in;
   lanes_type                lanes_ff, lanes_in;
   logic [LENGTH_BITS-1:0]   len_ff, len_in;
   logic                     long_ff, long_in;
   logic                     alt_ff, alt_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     addf_ff, addf_in;
   logic                     fin_ff, fin_in;
   logic                     last_ff, last_in;
   logic [2*LENGTH_BITS-1:0] prod_ff, prod_in;
   logic                     out_valid_ff, out_valid_in;
   logic [63:0]              out_first_ff, out_first_in, out_second_ff, out_second_in;

   lanes_type                base, stepped;
   logic [LENGTH_BITS-1:0]   quo;
   logic [LENGTH_BITS+6:0]   quo96;
   logic [6:0]               rmd;
   logic                     out_free;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_hash_first  = out_first_ff;
   assign rsp_hash_second = out_second_ff;
   assign out_free        = !out_valid_ff || rsp_pop;

   // seeded lanes for a first word, else the running lanes
   always_comb begin
      base = lanes_ff;
      if (q_entry.init) begin
         for (int i = 0; i < LANES; i++) begin
            case (i % 3)
               0:       base[i] = q_entry.seed1;
               1:       base[i] = q_entry.seed2;
               default: base[i] = SPK_CONST;
            endcase
         end
         if (!q_entry.is_long) begin
            base[3] = SPK_CONST;
         end
      end
   end

   // three round steps per cycle
   always_comb begin
      stepped = lanes_ff;
      for (int k = 0; k < 3; k++) begin
         stepped = round_step(stepped, 4'(cnt_ff) * 4'd3 + 4'(k), addf_ff);
      end
   end

   // remainder of the length by the block size
   always_comb begin
      quo   = LENGTH_BITS'(prod_ff >> RECIP_SHIFT);
      quo96 = {1'b0, quo, 6'b0} + {2'b0, quo, 5'b0};
      rmd   = 7'(len_ff - quo96[LENGTH_BITS-1:0]);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      lanes_in      = lanes_ff;
      len_in        = len_ff;
      long_in       = long_ff;
      alt_in        = alt_ff;
      cnt_in        = cnt_ff;
      addf_in       = addf_ff;
      fin_in        = fin_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      q_pop         = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               lanes_in = base;
               last_in  = q_entry.last;
               cnt_in   = 2'd0;
               addf_in  = 1'b1;
               fin_in   = 1'b0;
               if (q_entry.init) begin
                  len_in  = q_entry.len;
                  long_in = q_entry.is_long;
               end
               if (q_entry.absorb) begin
                  case (q_entry.op)
                     OP_SH_ADD2:     lanes_in[2] = base[2] + q_entry.word;
                     OP_SH_ADD3_MIX: lanes_in[3] = base[3] + q_entry.word;
                     OP_SH_XOR2:     lanes_in[2] = base[2] ^ q_entry.word;
                     OP_SH_XOR3_MIX: lanes_in[3] = base[3] ^ q_entry.word;
                     OP_SH_ADD3:     lanes_in[3] = base[3] + q_entry.word;
                     OP_LG_ADD2: begin
                        lanes_in[q_entry.lane] = base[q_entry.lane]
                                               + {q_entry.word[62:0], 1'b0};
                     end
                     default: begin
                        lanes_in[q_entry.lane] = base[q_entry.lane] + q_entry.word;
                     end
                  endcase
               end
               if (q_entry.absorb && (q_entry.op == OP_SH_ADD3_MIX ||
                                      q_entry.op == OP_SH_XOR3_MIX)) begin
                  state_in = ST_SMIX;
                  alt_in   = (q_entry.op == OP_SH_XOR3_MIX);
               end else if (q_entry.absorb && q_entry.op == OP_LG_ADD_ROUND) begin
                  state_in = ST_ROUND;
               end else if (q_entry.last) begin
                  state_in = (q_entry.init ? q_entry.is_long : long_ff)
                           ? ST_FIN_MUL : ST_FIN_SH1;
               end
            end
         end
         ST_SMIX: begin
            lanes_in = short_mix(lanes_ff, alt_ff);
            state_in = last_ff ? ST_FIN_SH1 : ST_RUN;
         end
         ST_ROUND: begin
            lanes_in = stepped;
            cnt_in   = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               if (fin_ff) begin
                  state_in = ST_FIN_OUT;
               end else if (last_ff) begin
                  state_in = ST_FIN_MUL;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_FIN_MUL: begin
            prod_in  = (2*LENGTH_BITS)'(len_ff) * (2*LENGTH_BITS)'(RECIP);
            state_in = ST_FIN_ADD;
         end
         ST_FIN_ADD: begin
            lanes_in[11] = lanes_ff[11] + {rmd, 57'b0};
            cnt_in       = 2'd0;
            addf_in      = 1'b0;
            fin_in       = 1'b1;
            state_in     = ST_ROUND;
         end
         ST_FIN_SH1: begin
            lanes_in[3] = lanes_ff[3] + {len_ff[7:0], 56'b0};
            if (len_ff[3:0] == 4'd0) begin
               lanes_in[2] = lanes_ff[2] + SPK_CONST;
               lanes_in[3] = lanes_ff[3] + {len_ff[7:0], 56'b0} + SPK_CONST;
            end
            state_in = ST_FIN_SH2;
         end
         ST_FIN_SH2: begin
            lanes_in[0] = rotl(lanes_ff[0] ^ lanes_ff[3], 6'd44);
            lanes_in[2] = lanes_ff[2] ^ lanes_in[0];
            lanes_in[1] = rotl(lanes_ff[1] ^ lanes_in[2], 6'd15);
            lanes_in[3] = lanes_ff[3] ^ lanes_in[1];
            state_in    = ST_FIN_SH3;
         end
         ST_FIN_SH3: begin
            lanes_in[0] = rotl(lanes_ff[0] ^ lanes_ff[3], 6'd34);
            lanes_in[2] = lanes_ff[2] ^ lanes_in[0];
            lanes_in[1] = rotl(lanes_ff[1] ^ lanes_in[2], 6'd21);
            lanes_in[3] = lanes_ff[3] ^ lanes_in[1];
            state_in    = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_first_in  = lanes_ff[0];
               out_second_in = lanes_ff[1];
               state_in      = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff      <= lanes_in;
      len_ff        <= len_in;
      long_ff       <= long_in;
      alt_ff        <= alt_in;
      cnt_ff        <= cnt_in;
      addf_ff       <= addf_in;
      fin_ff        <= fin_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
   end
endmodule

[rtl/spooky_style_hash_128.sv]
// Finish of a message after its last request: short path ST_FIN_SH1 to ST_FIN_SH3, then
// ST_FIN_OUT (ST_SMIX first after a group end); long path ST_FIN_MUL, ST_FIN_ADD, ST_ROUND,
// ST_FIN_OUT (ST_ROUND first after a block end). Throughput: one word per cycle; short
// group-end mixing, 96-byte block-end rounds (three steps per cycle) and finishing hold it.
// A four-entry request queue lets the front keep taking words while the back mixes.
// Reset (synchronous, active high) empties the queue and result register, ends any message.
`timescale 1ns / 1ps
module spooky_style_hash_128 import spk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   input  logic [31:0] req_msg_length,
   input  logic [63:0] req_seed_first,
   input  logic [63:0] req_seed_second,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_hash_first,
   output logic [63:0] rsp_hash_second
);
   entry_type q_wdata, q_rdata;
   logic      q_push, q_full, q_pop, q_empty;

   assign req_full = q_full;

   spk_front u_front (
      .clock, .reset, .req_push, .req_data_word, .req_valid_bytes, .req_last,
      .req_msg_length, .req_seed_first, .req_seed_second,
      .q_full, .q_push, .q_entry(q_wdata)
   );

   spk_queue u_queue (
      .clock, .reset, .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
   );

   spk_back u_back (
      .clock, .reset, .q_entry(q_rdata), .q_empty, .q_pop,
      .rsp_pop, .rsp_empty, .rsp_hash_first, .rsp_hash_second
   );
endmodule

[rtl/spk_checker.sv]
// Port checker for the hash block and its bind
`timescale 1ns / 1ps
`include "spooky_style_hash_128_macros.svh"
module spk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [63:0] rsp_hash_first,
   input logic [63:0] rsp_hash_second
);
   // a waiting result holds until taken
   `SPK_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_hash_first) && $stable(rsp_hash_second))
   // reset leaves no result and an open queue
   `SPK_ASSERT_RESET(a_rst_empty, rsp_empty)
   `SPK_ASSERT_RESET(a_rst_open, !req_full)
endmodule

bind spooky_style_hash_128 spk_checker u_spk_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_hash_first, .rsp_hash_second
);

[tb/spooky_style_hash_128_tb.sv]
// Testbench of the seeded 128-bit hash block: message stimulus, prediction and result checks
`timescale 1ns / 1ps
module spooky_style_hash_128_tb;
   import spk_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_last = 1'b0;
   logic [31:0] req_msg_length = '0;
   logic [63:0] req_seed_first = '0;
   logic [63:0] req_seed_second = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_hash_first;
   logic [63:0] rsp_hash_second;

   spooky_style_hash_128 uut (.*);

   always #5 clock = ~clock;

   // hash model state
   logic [63:0]     hl_lane [12];
   longint unsigned hl_taken, hl_len;
   bit              hl_long, hl_busy;

   typedef struct {
      logic [63:0] first;
      logic [63:0] second;
   } digest_type;
   digest_type digest_q[$];

   int unsigned n_words, n_msgs, n_digests, n_errors;
   bit          tx_fast, rx_fast;
   int unsigned hold_ticket = 0, hold_seen = 0, hold_left = 0, rx_wait = 0;

   function automatic logic [63:0] rot64(input logic [63:0] x, input int unsigned r);
      r = r % 64;
      return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
   endfunction

   function void lane_pass(input bit add_first);
      int unsigned rt [12] = '{44, 15, 34, 21, 14, 13, 11, 25, 42, 9, 35, 39};
      int unsigned p, q, s;
      for (int j = 0; j < 12; j++) begin
         p = (j + 11) % 12;
         q = (j + 1) % 12;
         s = (j + 2) % 12;
         if (add_first) hl_lane[p] = hl_lane[p] + hl_lane[q];
         else hl_lane[p] = hl_lane[p] ^ hl_lane[q];
         hl_lane[s] = hl_lane[s] ^ hl_lane[p];
         hl_lane[q] = rot64(hl_lane[q], rt[j]);
      end
   endfunction

   function void quad_mix(input int unsigned r1, input int unsigned r2);
      hl_lane[0] = rot64(hl_lane[0] ^ hl_lane[2], r1);
      hl_lane[3] = hl_lane[3] ^ hl_lane[0];
      hl_lane[1] = rot64(hl_lane[1] ^ hl_lane[3], r2);
      hl_lane[2] = hl_lane[2] ^ hl_lane[1];
   endfunction

   function automatic longint unsigned tail_start(input longint unsigned len);
      return ((len & 31) >= 16) ? (len & ~64'd31) + 16 : (len & ~64'd31);
   endfunction

   // absorbs one accepted request; returns 1 with the digest on the last word
   function bit hash_word(input logic [63:0] d, input logic [3:0] vb, input logic lst,
                          input logic [31:0] ml, input logic [63:0] s1,
                          input logic [63:0] s2, output digest_type dg);
      longint unsigned off, n, g, ts, lb, r;
      logic [63:0] w;
      int unsigned k;
      if (!hl_busy) begin
         hl_len  = ml;
         hl_long = hl_len >= SHORT_LIMIT;
         for (int i = 0; i < 12; i++)
            hl_lane[i] = (i % 3 == 0) ? s1 : (i % 3 == 1) ? s2 : SPK_CONST;
         if (!hl_long) hl_lane[3] = SPK_CONST;
         hl_taken = 0;
         hl_busy  = 1;
      end
      off = hl_taken;
      if (off < hl_len) begin
         n = (vb > 8) ? 8 : vb;
         if (hl_len - off < n) n = hl_len - off;
         w = (n >= 8) ? d : d & ((64'd1 << (8 * n)) - 1);
         if (hl_long) begin
            lb = hl_len - (hl_len % BLOCK_BYTES);
            if (off < lb) begin
               k = (off >> 3) % 12;
               hl_lane[k] += w;
               if (k == 11) lane_pass(1'b1);
            end else begin
               k = ((off - lb) >> 3) % 12;
               hl_lane[k] += w + w;
            end
         end else begin
            g  = hl_len & ~64'd31;
            ts = tail_start(hl_len);
            k  = (off >> 3) & 3;
            if (off < g) begin
               case (k)
                  0: hl_lane[2] += w;
                  1: begin hl_lane[3] += w; quad_mix(50, 52); end
                  2: hl_lane[2] ^= w;
                  default: begin hl_lane[3] ^= w; quad_mix(23, 5); end
               endcase
            end else if (off < ts) begin
               if ((k & 1) == 0) hl_lane[2] += w;
               else begin hl_lane[3] += w; quad_mix(50, 52); end
            end else if (((off - ts) >> 3) == 0) hl_lane[2] += w;
            else hl_lane[3] += w;
         end
         hl_taken = off + 8;
      end
      if (!lst) return 0;
      // finishing rounds
      if (hl_long) begin
         r = hl_len % BLOCK_BYTES;
         hl_lane[11] += (r << 56) + (r << 56);
         lane_pass(1'b0);
      end else begin
         hl_lane[3] += hl_len << 56;
         if (hl_len == tail_start(hl_len)) begin
            hl_lane[2] += SPK_CONST;
            hl_lane[3] += SPK_CONST;
         end
         hl_lane[0] = rot64(hl_lane[0] ^ hl_lane[3], 44); hl_lane[2] ^= hl_lane[0];
         hl_lane[1] = rot64(hl_lane[1] ^ hl_lane[2], 15); hl_lane[3] ^= hl_lane[1];
         hl_lane[0] = rot64(hl_lane[0] ^ hl_lane[3], 34); hl_lane[2] ^= hl_lane[0];
         hl_lane[1] = rot64(hl_lane[1] ^ hl_lane[2], 21); hl_lane[3] ^= hl_lane[1];
      end
      dg.first  = hl_lane[0];
      dg.second = hl_lane[1];
      hl_busy   = 0;
      return 1;
   endfunction

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side: check each accepted digest, then draw the next stall
   always @(posedge clock) begin
      digest_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
         rx_wait <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            n_digests++;
            if (digest_q.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected result %h %h", $time, rsp_hash_first,
                        rsp_hash_second);
            end else begin
               e = digest_q.pop_front();
               if (rsp_hash_first !== e.first) begin
                  n_errors++;
                  $display("%0t: hash_first expected %h actual %h", $time, e.first,
                           rsp_hash_first);
               end
               if (rsp_hash_second !== e.second) begin
                  n_errors++;
                  $display("%0t: hash_second expected %h actual %h", $time, e.second,
                           rsp_hash_second);
               end
            end
         end
         if (hold_left > 1 || hold_ticket != hold_seen) begin
            rsp_pop <= 1'b0;
         end else if (rsp_pop && !rsp_empty) begin
            rx_wait <= rx_fast ? 0 : $urandom_range(0, 11);
            rsp_pop <= rx_fast;
         end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            rsp_pop <= (rx_wait == 1);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // offers one request after a random gap and waits for it to be taken
   task send_word(input logic [63:0] d, input logic [3:0] vb, input logic lst,
                  input logic [31:0] ml, input logic [63:0] s1, input logic [63:0] s2);
      int unsigned gap;
      digest_type dg;
      gap = tx_fast ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_data_word   <= d;
      req_valid_bytes <= vb;
      req_last        <= lst;
      req_msg_length  <= ml;
      req_seed_first  <= s1;
      req_seed_second <= s2;
      do @(posedge clock); while (req_full !== 1'b0);
      n_words++;
      if (hash_word(d, vb, lst, ml, s1, s2, dg)) digest_q.push_back(dg);
   endtask

   // one message; noisy ones break the rules in a random way
   task send_msg(input logic [31:0] len, input int unsigned nw, input bit noisy,
                 input logic [63:0] s1, input logic [63:0] s2);
      longint unsigned left;
      logic [63:0] d;
      logic [3:0]  vb;
      left = len;
      for (int unsigned i = 0; i < nw; i++) begin
         d  = {$urandom, $urandom};
         vb = (left >= 8) ? 4'd8 : 4'(left);
         if (!(noisy && $urandom_range(0, 3) == 0) && vb < 8)
            d = d & ((64'd1 << (8 * vb)) - 1);
         if (noisy && $urandom_range(0, 3) == 0) vb = 4'($urandom_range(0, 15));
         if (i == 0) send_word(d, vb, i == nw - 1, len, s1, s2);
         else send_word(d, vb, i == nw - 1, $urandom, {$urandom, $urandom},
                        {$urandom, $urandom});
         left = (left > 8) ? left - 8 : 0;
      end
      n_msgs++;
   endtask

   task wait_drained();
      req_push <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // edges of the short and long path, oversize valid counts, early and late ends
   task test_directed();
      send_msg(0, 1, 0, '0, '0);
      send_msg(7, 1, 0, '1, '1);
      send_msg(16, 2, 0, {$urandom, $urandom}, '0);
      send_msg(31, 4, 0, '0, '1);
      send_word('1, 4'd15, 0, 9, 64'h0123456789abcdef, '1);
      send_word('1, 4'd15, 1, 0, '0, '0);
      send_msg(300, 3, 0, '1, '0);
      send_msg(32'hffffffff, 2, 0, '1, '1);
      send_msg(4, 3, 0, {$urandom, $urandom}, {$urandom, $urandom});
      send_word('1, 4'd3, 0, 24, '0, '0);
      send_word('1, 4'd8, 0, 0, '1, '1);
      send_word('1, 4'd8, 1, 0, '1, '1);
      wait_drained();
   endtask

   // mostly well-formed messages of random length and random content
   task test_random();
      logic [31:0] len;
      int unsigned nw;
      bit noisy;
      while (n_words < 1100 || n_msgs < 70) begin
         tx_fast <= ($urandom_range(0, 4) == 0);
         rx_fast <= ($urandom_range(0, 4) == 0);
         noisy = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 7))
            0: len = $urandom_range(0, 40);
            1, 2: len = $urandom_range(0, 191);
            3, 4: len = $urandom_range(192, 400);
            5: len = 96 * $urandom_range(2, 4) + $urandom_range(0, 1);
            6: len = 32 * $urandom_range(0, 5) + 16 * $urandom_range(0, 1);
            default: len = $urandom_range(0, 700);
         endcase
         nw = (len + 7) / 8;
         if (nw == 0) nw = 1;
         if (noisy) begin
            if ($urandom_range(0, 1)) nw = $urandom_range(1, nw);
            else nw = nw + $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) len = $urandom;
            if (len > 1000) nw = $urandom_range(1, 6);
         end
         send_msg(len, nw, noisy, {$urandom, $urandom}, {$urandom, $urandom});
      end
      tx_fast <= 1'b0;
      rx_fast <= 1'b0;
      wait_drained();
   endtask

   // results held off while the sender keeps pushing, so the block stalls
   task test_backpressure();
      tx_fast     <= 1'b1;
      hold_ticket <= hold_ticket + 1;
      for (int i = 0; i < 6; i++)
         send_msg(24 + 8 * i, 3 + i, 0, {$urandom, $urandom}, {$urandom, $urandom});
      send_msg(200, 25, 0, {$urandom, $urandom}, {$urandom, $urandom});
      tx_fast <= 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      $display("Covered %0d messages in %0d request words, %0d digests checked.",
               n_msgs, n_words, n_digests);
      if (n_errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/spk_pkg.sv
rtl/spk_queue.sv
rtl/spk_front.sv
rtl/spk_back.sv
rtl/spooky_style_hash_128.sv
rtl/spk_checker.sv
tb/spooky_style_hash_128_tb.sv
